@@ design/ncpe_pkg.sv @@
// ----------------------------------------------------------------------------
// NURBS curve point evaluator package
// Shared sizes, codes, command and configuration types for the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ncpe_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_DEGREE = 7;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int DEG_W      = 3;
	localparam int KIDX_W     = $clog2(MAX_POINTS + MAX_DEGREE + 1);
	localparam int U_W        = 17;
	localparam int FRAC_W     = 16;
	localparam int COORD_W    = 32;
	localparam int WGT_W      = 24;
	localparam int FLOOR_W    = 16;
	localparam int EW_W       = 25;
	localparam int WSUM_W     = 28;
	localparam int ACC_W      = 61;
	localparam int DIV_W      = 64;
	localparam int DVS_W      = 32;
	localparam int PROD_W     = 34;
	localparam int DEN_W      = 18;

	localparam logic [U_W-1:0] UNIT_Q16 = 17'h10000;

	localparam logic [1:0] OP_WRITE_POINT  = 2'd0;
	localparam logic [1:0] OP_WRITE_WEIGHT = 2'd1;
	localparam logic [1:0] OP_EVALUATE     = 2'd2;
	localparam logic [1:0] OP_RESERVED     = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INDEX      = 3'd1;
	localparam logic [2:0] ST_WEIGHT     = 3'd2;
	localparam logic [2:0] ST_U_RANGE    = 3'd3;
	localparam logic [2:0] ST_ZERO_WSUM  = 3'd4;
	localparam logic [2:0] ST_BAD_CONFIG = 3'd5;

	localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_CURVE_DEGREE = 2'd1;
	localparam logic [1:0] CFG_WEIGHT_FLOOR = 2'd2;

	typedef enum logic [1:0] {
		CMD_REPORT,
		CMD_WRITE_POINT,
		CMD_WRITE_WEIGHT,
		CMD_EVALUATE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [2:0]                 status;
		logic [IDX_W-1:0]           idx;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic [WGT_W-1:0]           weight;
		logic [U_W-1:0]             u;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]   point_count;
		logic [DEG_W-1:0]   degree;
		logic [FLOOR_W-1:0] weight_floor;
		logic               ok;
	} cfg_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_SPAN,
		B_KNOT,
		B_KWAIT,
		B_RMUL,
		B_RHI,
		B_RHIW,
		B_RLO,
		B_RLOW,
		B_RUPD,
		B_SRD,
		B_SW,
		B_SM,
		B_SA,
		B_CHK,
		B_DIVS,
		B_DIVW,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

@@ design/ncpe_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/ncpe_div.sv @@
// ----------------------------------------------------------------------------
// NURBS evaluator divider
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpe_div
	import ncpe_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quotient
);

	logic                       run_q;
	logic                       done_q;
	logic [$clog2(DIV_W)-1:0]   cnt_q;
	logic [DIV_W-1:0]           num_q;
	logic [DVS_W:0]             rem_q;
	logic [DVS_W-1:0]           dvs_q;
	logic [DVS_W:0]             trial;
	logic                       fits;

	assign trial = {rem_q[DVS_W-1:0], num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(DIV_W)'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			num_q <= {num_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

@@ design/ncpe_front.sv @@
// ----------------------------------------------------------------------------
// NURBS evaluator front end
// Accepts items, checks them against the configuration and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpe_front
	import ncpe_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 opcode,
	input  wire logic [IDX_W-1:0]           point_index,
	input  wire logic signed [COORD_W-1:0]  point_x,
	input  wire logic signed [COORD_W-1:0]  point_y,
	input  wire logic signed [COORD_W-1:0]  point_z,
	input  wire logic [WGT_W-1:0]           weight_value,
	input  wire logic [U_W-1:0]             param_u,
	input  wire cfg_t                       cfg,
	input  wire logic                       pop,
	output cmd_t                            head,
	output logic                            head_valid
);

	cmd_t       cmd;
	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	always_comb begin
		cmd        = '0;
		cmd.idx    = point_index;
		cmd.x      = point_x;
		cmd.y      = point_y;
		cmd.z      = point_z;
		cmd.weight = weight_value;
		cmd.u      = param_u;
		cmd.kind   = CMD_REPORT;
		cmd.status = ST_OK;
		if (!cfg.ok || opcode == OP_RESERVED) begin
			cmd.status = ST_BAD_CONFIG;
		end else if (opcode == OP_EVALUATE) begin
			if (param_u > UNIT_Q16) begin
				cmd.status = ST_U_RANGE;
			end else begin
				cmd.kind = CMD_EVALUATE;
			end
		end else if (CNT_W'(point_index) >= cfg.point_count) begin
			cmd.status = ST_INDEX;
		end else if (opcode == OP_WRITE_POINT) begin
			cmd.kind = CMD_WRITE_POINT;
		end else if (weight_value <= WGT_W'(cfg.weight_floor)) begin
			cmd.status = ST_WEIGHT;
		end else begin
			cmd.kind = CMD_WRITE_WEIGHT;
		end
	end

	assign busy       = count_q == 2'd2;
	assign push       = start && !busy;
	assign head       = queue_q[rd_ptr_q];
	assign head_valid = count_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

`default_nettype wire

@@ design/ncpe_back.sv @@
// ----------------------------------------------------------------------------
// NURBS evaluator back end
// Executes queued commands: store writes, error reports and the iterative curve evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpe_back
	import ncpe_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire cmd_t                   head,
	input  wire logic                   head_valid,
	output logic                        pop,
	output logic                        done,
	output logic [2:0]                  status,
	output logic signed [COORD_W-1:0]   pos_x,
	output logic signed [COORD_W-1:0]   pos_y,
	output logic signed [COORD_W-1:0]   pos_z
);

	back_state_t state_q, state_d;

	cmd_t                      cmd_q;
	logic [KIDX_W-1:0]         span_q;
	logic [DEG_W-1:0]          j_q;
	logic [DEG_W-1:0]          r_q;
	logic [DEG_W-1:0]          c_q;
	logic                      side_q;
	logic [1:0]                ax_q;
	logic [U_W-1:0]            basis_q [MAX_DEGREE+1];
	logic [U_W-1:0]            lft_q   [MAX_DEGREE+1];
	logic [U_W-1:0]            rgt_q   [MAX_DEGREE+1];
	logic [U_W-1:0]            saved_q;
	logic [U_W-1:0]            hi_q;
	logic [U_W-1:0]            lo_q;
	logic [DEN_W-1:0]          den_q;
	logic [PROD_W-1:0]         prod_hi_q;
	logic [PROD_W-1:0]         prod_lo_q;
	logic [EW_W-1:0]           w_q;
	logic signed [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic signed [COORD_W+EW_W:0] px_q, py_q, pz_q;
	logic signed [ACC_W-1:0]   sx_q, sy_q, sz_q;
	logic [WSUM_W-1:0]         wsum_q;
	logic [2:0]                status_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q, res_z_q;
	logic [MAX_POINTS-1:0]     pvld_q;
	logic [MAX_POINTS-1:0]     wvld_q;

	logic [CNT_W-1:0]          m;
	logic [KIDX_W-1:0]         p_k;
	logic [KIDX_W-1:0]         n_k;
	logic [KIDX_W-1:0]         kidx;
	logic                      k_low;
	logic                      k_direct;
	logic [U_W-1:0]            k_val;
	logic [U_W:0]              u_inc;
	logic [U_W+CNT_W:0]        span_prod;
	logic [CNT_W-1:0]          span_t;
	logic [DEN_W-1:0]          den;
	logic [DEG_W-1:0]          rp1;
	logic [DEG_W-1:0]          jmr;
	logic                      last_r;
	logic [KIDX_W-1:0]         sum_idx;
	logic [IDX_W-1:0]          raddr;
	logic [3*COORD_W-1:0]      pt_rdata;
	logic [WGT_W-1:0]          wt_rdata;
	logic [WGT_W-1:0]          wt_eff;
	logic [WGT_W+U_W-1:0]      wprod;
	logic signed [ACC_W-1:0]   acc_sel;
	logic [ACC_W-1:0]          acc_mag;
	logic                      acc_neg;
	logic [DIV_W-1:0]          div_quot;
	logic                      div_done;
	logic                      div_start;
	logic [DIV_W-1:0]          div_dividend;
	logic [DVS_W-1:0]          div_divisor;
	logic signed [COORD_W-1:0] sat_val;
	logic                      pt_we;
	logic                      wt_we;

	assign m         = cfg.point_count - CNT_W'(cfg.degree);
	assign p_k       = KIDX_W'(cfg.degree);
	assign n_k       = KIDX_W'(cfg.point_count);
	assign kidx      = side_q ? (span_q + KIDX_W'(j_q)) : (span_q + 1'b1 - KIDX_W'(j_q));
	assign k_low     = kidx <= p_k;
	assign k_direct  = k_low || (kidx >= n_k);
	assign k_val     = k_direct ? (k_low ? '0 : UNIT_Q16) : div_quot[U_W-1:0];
	assign u_inc     = {1'b0, cmd_q.u} + 1'b1;
	assign span_prod = (U_W+CNT_W+1)'(u_inc) * (U_W+CNT_W+1)'(m) - 1'b1;
	assign span_t    = (span_prod[U_W+CNT_W:FRAC_W] > (U_W+CNT_W-FRAC_W+1)'(m - 1'b1)) ?
	                   (m - 1'b1) : CNT_W'(span_prod[U_W+CNT_W:FRAC_W]);
	assign rp1       = r_q + 1'b1;
	assign jmr       = j_q - r_q;
	assign den       = {1'b0, rgt_q[rp1]} + {1'b0, lft_q[jmr]};
	assign last_r    = {1'b0, r_q} + 1'b1 == {1'b0, j_q};
	assign sum_idx   = span_q - p_k + KIDX_W'(c_q);
	assign raddr     = sum_idx[IDX_W-1:0];
	assign wt_eff    = wvld_q[raddr] ? wt_rdata : WGT_W'(UNIT_Q16);
	assign wprod     = wt_eff * basis_q[c_q];
	assign acc_sel   = (ax_q == 2'd0) ? sx_q : ((ax_q == 2'd1) ? sy_q : sz_q);
	assign acc_neg   = acc_sel[ACC_W-1];
	assign acc_mag   = acc_neg ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);

	always_comb begin
		if (!acc_neg) begin
			sat_val = (div_quot > DIV_W'(32'h7fffffff)) ? 32'sh7fffffff :
			          signed'(div_quot[COORD_W-1:0]);
		end else begin
			sat_val = (div_quot > DIV_W'(32'h80000000)) ? 32'sh80000000 :
			          signed'(COORD_W'(-div_quot[COORD_W-1:0]));
		end
	end

	always_comb begin
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			B_KNOT: begin
				div_dividend = DIV_W'({kidx - p_k, {FRAC_W{1'b0}}});
				div_divisor  = DVS_W'(m);
			end
			B_RHI: begin
				div_dividend = DIV_W'(prod_hi_q);
				div_divisor  = DVS_W'(den_q);
			end
			B_RLO: begin
				div_dividend = DIV_W'(prod_lo_q);
				div_divisor  = DVS_W'(den_q);
			end
			B_DIVS: begin
				div_dividend = DIV_W'(acc_mag);
				div_divisor  = DVS_W'(wsum_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					state_d = (head.kind == CMD_EVALUATE) ? B_SPAN : B_DONE;
				end
			end
			B_SPAN:  state_d = (cfg.degree == '0) ? B_SRD : B_KNOT;
			B_KNOT: begin
				if (!k_direct) begin
					state_d = B_KWAIT;
				end else if (side_q) begin
					state_d = B_RMUL;
				end
			end
			B_KWAIT: begin
				if (div_done) begin
					state_d = side_q ? B_RMUL : B_KNOT;
				end
			end
			B_RMUL:  state_d = (den == '0) ? B_RUPD : B_RHI;
			B_RHI:   state_d = B_RHIW;
			B_RHIW:  state_d = div_done ? B_RLO : B_RHIW;
			B_RLO:   state_d = B_RLOW;
			B_RLOW:  state_d = div_done ? B_RUPD : B_RLOW;
			B_RUPD: begin
				if (!last_r) begin
					state_d = B_RMUL;
				end else if (j_q == cfg.degree) begin
					state_d = B_SRD;
				end else begin
					state_d = B_KNOT;
				end
			end
			B_SRD:   state_d = B_SW;
			B_SW:    state_d = B_SM;
			B_SM:    state_d = B_SA;
			B_SA:    state_d = (c_q == cfg.degree) ? B_CHK : B_SRD;
			B_CHK: begin
				if (wsum_q == '0 || wsum_q < WSUM_W'(cfg.weight_floor)) begin
					state_d = B_DONE;
				end else begin
					state_d = B_DIVS;
				end
			end
			B_DIVS:  state_d = B_DIVW;
			B_DIVW: begin
				if (div_done) begin
					state_d = (ax_q == 2'd2) ? B_DONE : B_DIVS;
				end
			end
			B_DONE:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		done      = 1'b0;
		div_start = 1'b0;
		pt_we     = 1'b0;
		wt_we     = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop   = head_valid;
				pt_we = head_valid && head.kind == CMD_WRITE_POINT;
				wt_we = head_valid && head.kind == CMD_WRITE_WEIGHT;
			end
			B_KNOT:  div_start = !k_direct;
			B_RHI:   div_start = 1'b1;
			B_RLO:   div_start = 1'b1;
			B_DIVS:  div_start = 1'b1;
			B_DONE:  done = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pvld_q  <= '0;
			wvld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pt_we) begin
				pvld_q[head.idx] <= 1'b1;
			end
			if (wt_we) begin
				wvld_q[head.idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cmd_q    <= head;
				status_q <= head.status;
				res_x_q  <= '0;
				res_y_q  <= '0;
				res_z_q  <= '0;
			end
			B_SPAN: begin
				span_q     <= p_k + KIDX_W'(span_t);
				basis_q[0] <= UNIT_Q16;
				j_q        <= DEG_W'(1);
				side_q     <= 1'b0;
				c_q        <= '0;
				sx_q       <= '0;
				sy_q       <= '0;
				sz_q       <= '0;
				wsum_q     <= '0;
			end
			B_KNOT, B_KWAIT: begin
				if (k_direct || (state_q == B_KWAIT && div_done)) begin
					if (side_q) begin
						rgt_q[j_q] <= k_val - cmd_q.u;
						side_q     <= 1'b0;
						r_q        <= '0;
						saved_q    <= '0;
					end else begin
						lft_q[j_q] <= cmd_q.u - k_val;
						side_q     <= 1'b1;
					end
				end
			end
			B_RMUL: begin
				den_q     <= den;
				prod_hi_q <= basis_q[r_q] * rgt_q[rp1];
				prod_lo_q <= basis_q[r_q] * lft_q[jmr];
				hi_q      <= '0;
				lo_q      <= '0;
			end
			B_RHIW: begin
				if (div_done) begin
					hi_q <= div_quot[U_W-1:0];
				end
			end
			B_RLOW: begin
				if (div_done) begin
					lo_q <= div_quot[U_W-1:0];
				end
			end
			B_RUPD: begin
				basis_q[r_q] <= saved_q + hi_q;
				saved_q      <= lo_q;
				if (last_r) begin
					basis_q[j_q] <= lo_q;
					j_q          <= j_q + 1'b1;
					c_q          <= '0;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
			B_SW: begin
				w_q    <= wprod[WGT_W+U_W-1:FRAC_W];
				pt_x_q <= pvld_q[raddr] ? signed'(pt_rdata[3*COORD_W-1:2*COORD_W]) : '0;
				pt_y_q <= pvld_q[raddr] ? signed'(pt_rdata[2*COORD_W-1:COORD_W]) : '0;
				pt_z_q <= pvld_q[raddr] ? signed'(pt_rdata[COORD_W-1:0]) : '0;
			end
			B_SM: begin
				px_q <= pt_x_q * signed'({1'b0, w_q});
				py_q <= pt_y_q * signed'({1'b0, w_q});
				pz_q <= pt_z_q * signed'({1'b0, w_q});
			end
			B_SA: begin
				sx_q   <= sx_q + ACC_W'(px_q);
				sy_q   <= sy_q + ACC_W'(py_q);
				sz_q   <= sz_q + ACC_W'(pz_q);
				wsum_q <= wsum_q + WSUM_W'(w_q);
				c_q    <= c_q + 1'b1;
			end
			B_CHK: begin
				ax_q <= '0;
				if (wsum_q == '0 || wsum_q < WSUM_W'(cfg.weight_floor)) begin
					status_q <= ST_ZERO_WSUM;
				end
			end
			B_DIVW: begin
				if (div_done) begin
					case (ax_q)
						2'd0:    res_x_q <= sat_val;
						2'd1:    res_y_q <= sat_val;
						default: res_z_q <= sat_val;
					endcase
					ax_q <= ax_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	ncpe_ram #(
		.WIDTH (3 * COORD_W),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (head.idx),
		.wdata ({head.x, head.y, head.z}),
		.raddr (raddr),
		.rdata (pt_rdata)
	);

	ncpe_ram #(
		.WIDTH (WGT_W),
		.DEPTH (MAX_POINTS)
	) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (head.idx),
		.wdata (head.weight),
		.raddr (raddr),
		.rdata (wt_rdata)
	);

	ncpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign status = status_q;
	assign pos_x  = res_x_q;
	assign pos_y  = res_y_q;
	assign pos_z  = res_z_q;

endmodule

`default_nettype wire

@@ design/nurbs_curve_point_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// NURBS curve point evaluator
// Holds control points, weights and curve configuration, and evaluates
// rational B-spline curve points on request.
//
// Channel   Signals                                        Handshake
// input     opcode point_index point_x/y/z weight_value    start, busy
//           param_u
// result    status pos_x pos_y pos_z                       done (one cycle)
// config    cfg_index cfg_data                             cfg_we
//
// A write item is stored as it leaves the queue; the done state then
// reports it. An evaluate item uses the shared 64-step divider for
// each inner knot, each of the at most p(p+1) basis-term quotients for
// degree p and each of the three final quotients. Two items can wait
// in the queue; busy is high when it is full. Reset restores the default
// configuration and marks every stored point as zero and every weight as one.
// Results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module nurbs_curve_point_evaluator_top
	import ncpe_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 opcode,
	input  wire logic [IDX_W-1:0]           point_index,
	input  wire logic signed [COORD_W-1:0]  point_x,
	input  wire logic signed [COORD_W-1:0]  point_y,
	input  wire logic signed [COORD_W-1:0]  point_z,
	input  wire logic [WGT_W-1:0]           weight_value,
	input  wire logic [U_W-1:0]             param_u,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [FLOOR_W-1:0]         cfg_data,
	output logic                            done,
	output logic [2:0]                      status,
	output logic signed [COORD_W-1:0]       pos_x,
	output logic signed [COORD_W-1:0]       pos_y,
	output logic signed [COORD_W-1:0]       pos_z
);

	logic [CNT_W-1:0]   point_count_q;
	logic [DEG_W-1:0]   curve_degree_q;
	logic [FLOOR_W-1:0] weight_floor_q;
	cfg_t               cfg;
	cmd_t               head;
	logic               head_valid;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q  <= CNT_W'(4);
			curve_degree_q <= DEG_W'(3);
			weight_floor_q <= FLOOR_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_COUNT:  point_count_q  <= cfg_data[CNT_W-1:0];
				CFG_CURVE_DEGREE: curve_degree_q <= cfg_data[DEG_W-1:0];
				CFG_WEIGHT_FLOOR: weight_floor_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.point_count  = point_count_q;
		cfg.degree       = curve_degree_q;
		cfg.weight_floor = weight_floor_q;
		cfg.ok           = (point_count_q >= CNT_W'(2)) &&
		                   (point_count_q <= CNT_W'(MAX_POINTS)) &&
		                   (CNT_W'(curve_degree_q) <= point_count_q - 1'b1);
	end

	ncpe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.weight_value (weight_value),
		.param_u      (param_u),
		.cfg          (cfg),
		.pop          (pop),
		.head         (head),
		.head_valid   (head_valid)
	);

	ncpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.done       (done),
		.status     (status),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z)
	);

endmodule

`default_nettype wire
